// ----- hw/rtl/cubemap_to_equirect_map_macros.svh -----
// ----------------------------------------------------------------------------
// Cube map to equirectangular mapper: assertion macros
// Concurrent check helpers; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef CUBEMAP_TO_EQUIRECT_MAP_MACROS_SVH
`define CUBEMAP_TO_EQUIRECT_MAP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define C2E_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c2e assertion failed");
`define C2E_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c2e assertion failed");
`else
`define C2E_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define C2E_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/c2e_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_pkg
// Shared types, constants and tables of the cube map to equirectangular mapper.
// ----------------------------------------------------------------------------
package c2e_pkg;

  localparam int FRAC_BITS_DEF = 6;

  localparam int PW_W     = 14;
  localparam int PH_W     = 13;
  localparam int COL_W    = 15;
  localparam int ROW_W    = 13;
  localparam int MAPX_W   = 20;
  localparam int MAPY_W   = 19;
  localparam int W_W      = 12;   // face edge, at most 3687
  localparam int XY_W     = 13;   // signed doubled face coordinates
  localparam int CFG_IDX_W = 2;

  localparam logic [29:0] KW = 30'd966707283;

  localparam int SQ_IN_W  = 25;   // X*X + P*P
  localparam int SQ_SHIFT = 32;
  localparam int SQ_STEPS = 29;   // result bits of the root
  localparam int SQ_REM_W = 31;

  localparam int CW           = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int SCALE_SH     = 16;

  localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd1073741824;
  localparam logic signed [CW-1:0] ANG_PI      = 34'sd2147483648;
  localparam logic signed [CW-1:0] ANG_3HALF_PI = 34'sd3221225472;

  localparam logic [MAPX_W-1:0] MAPX_MAX = 20'hFFFFF;
  localparam logic [MAPY_W-1:0] MAPY_MAX = 19'h7FFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  localparam logic [CFG_IDX_W-1:0] REG_EQ_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EQ_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_STRIP = 2'd2;

  typedef enum logic [2:0] {
    FACE_LEFT, FACE_MID, FACE_RIGHT, FACE_BACK, FACE_TOP, FACE_BOTTOM
  } face_t;

  typedef struct packed {
    logic                   outside;
    face_t                  face;
    logic signed [XY_W-1:0] fx;
    logic signed [XY_W-1:0] fy;
    logic [W_W-1:0]         w;
  } item_t;

  typedef struct packed {
    logic  outside;
    face_t face;
    logic  x_neg;
    logic  center;
  } tag_t;

  typedef struct packed {
    tag_t                   tag;
    logic signed [CW-1:0]   c1x;
    logic signed [CW-1:0]   c1y;
    logic [W_W-1:0]         w;
    logic signed [XY_W-1:0] fy;
  } sq_sb_t;

endpackage

// ----- hw/rtl/c2e_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_front
// Takes pixel requests, finds the face and the doubled face coordinates.
// ----------------------------------------------------------------------------
module c2e_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [c2e_pkg::COL_W-1:0]     col,
  input  logic [c2e_pkg::ROW_W-1:0]     row,
  input  logic [c2e_pkg::PW_W-1:0]      eq_width,
  input  logic                          layout_strip,
  input  logic                          full,
  output logic                          busy,
  output logic                          push,
  output c2e_pkg::item_t                item
);

  logic                          advance;
  logic [43:0]                   wprod;
  logic                          s1_valid;
  logic [c2e_pkg::COL_W-1:0]     s1_col;
  logic [c2e_pkg::ROW_W-1:0]     s1_row;
  logic [c2e_pkg::W_W-1:0]       s1_w;
  logic                          s1_strip;
  logic                          s2_valid;
  c2e_pkg::item_t                s2_item;
  c2e_pkg::item_t                item_next;
  logic [15:0] w16, w2, w3, cols, rows, c16, r16, bx, by, u, v;
  logic        hi, fj, fi1, fi2;
  logic signed [14:0] xs, ys;

  assign advance = !full;
  assign busy    = full;
  assign wprod   = eq_width * c2e_pkg::KW;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= start;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_col   <= col;
      s1_row   <= row;
      s1_w     <= wprod[32 +: c2e_pkg::W_W];
      s1_strip <= layout_strip;
      s2_item  <= item_next;
    end
  end

  always_comb begin
    w16  = 16'(s1_w);
    w2   = w16 << 1;
    w3   = w16 + w2;
    cols = s1_strip ? (w3 << 1) : w3;
    rows = s1_strip ? w16 : w2;
    c16  = 16'(s1_col);
    r16  = 16'(s1_row);
    hi   = c16 >= w3;
    bx   = hi ? c16 - w3 : c16;
    by   = hi ? r16 + w16 : r16;
    fj   = by >= w16;
    v    = fj ? by - w16 : by;
    fi2  = bx >= w2;
    fi1  = bx >= w16;
    u    = fi2 ? bx - w2 : (fi1 ? bx - w16 : bx);
    xs   = $signed({1'b0, u[12:0], 1'b0}) - $signed(15'(s1_w));
    ys   = $signed(15'(s1_w)) - $signed({1'b0, v[12:0], 1'b0});
    item_next.outside = (s1_w == '0) || (c16 >= cols) || (r16 >= rows);
    item_next.fx = xs[c2e_pkg::XY_W-1:0];
    item_next.fy = ys[c2e_pkg::XY_W-1:0];
    item_next.w  = s1_w;
    priority if (!fj && !fi1) item_next.face = c2e_pkg::FACE_LEFT;
    else if (!fj && !fi2)     item_next.face = c2e_pkg::FACE_MID;
    else if (!fj)             item_next.face = c2e_pkg::FACE_RIGHT;
    else if (!fi1)            item_next.face = c2e_pkg::FACE_BACK;
    else if (!fi2)            item_next.face = c2e_pkg::FACE_TOP;
    else                      item_next.face = c2e_pkg::FACE_BOTTOM;
  end

  assign push = s2_valid && advance;
  assign item = s2_item;

endmodule

// ----- hw/rtl/c2e_queue.sv -----
`timescale 1ns / 1ps
`include "cubemap_to_equirect_map_macros.svh"
// ----------------------------------------------------------------------------
// c2e_queue
// Short request queue between the classifier and the math pipeline.
// ----------------------------------------------------------------------------
module c2e_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  c2e_pkg::item_t din,
  input  logic           pop,
  output c2e_pkg::item_t dout,
  output logic           full,
  output logic           empty
);

  c2e_pkg::item_t                mem [c2e_pkg::QUEUE_DEPTH];
  logic [c2e_pkg::QPTR_W-1:0]    wr_ptr;
  logic [c2e_pkg::QPTR_W-1:0]    rd_ptr;
  logic [c2e_pkg::QCNT_W-1:0]    count;

  assign full  = count == c2e_pkg::QCNT_W'(c2e_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == c2e_pkg::QPTR_W'(c2e_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == c2e_pkg::QPTR_W'(c2e_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `C2E_ASSERT_IMPL(a_no_push_full, clk, rst, push, !full)
  `C2E_ASSERT_IMPL(a_no_pop_empty, clk, rst, pop, !empty)
  `C2E_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, !empty)

endmodule

// ----- hw/rtl/c2e_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_isqrt
// Pipelined digit-by-digit root: floor(sqrt(s) * 2^16), one bit per stage.
// ----------------------------------------------------------------------------
module c2e_isqrt (
  input  logic                            clk,
  input  logic [c2e_pkg::SQ_IN_W-1:0]     s_in,
  output logic [c2e_pkg::SQ_STEPS-1:0]    root
);

  localparam int VW = 2 * c2e_pkg::SQ_STEPS;

  logic [c2e_pkg::SQ_REM_W-1:0]  rem_s  [c2e_pkg::SQ_STEPS];
  logic [c2e_pkg::SQ_STEPS-1:0]  root_s [c2e_pkg::SQ_STEPS];
  logic [c2e_pkg::SQ_IN_W-1:0]   val_s  [c2e_pkg::SQ_STEPS];

  for (genvar i = 0; i < c2e_pkg::SQ_STEPS; i++) begin : g_step
    logic [c2e_pkg::SQ_REM_W-1:0] rem_p;
    logic [c2e_pkg::SQ_STEPS-1:0] root_p;
    logic [c2e_pkg::SQ_IN_W-1:0]  val_p;
    logic [VW-1:0]                vext;
    logic [c2e_pkg::SQ_REM_W+1:0] r2, t;
    logic                         ge;
    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign val_p  = s_in;
    end else begin : g_rest
      assign rem_p  = rem_s[i-1];
      assign root_p = root_s[i-1];
      assign val_p  = val_s[i-1];
    end
    always_comb begin
      vext = VW'({val_p, c2e_pkg::SQ_SHIFT'(0)});
      r2   = {rem_p, vext[VW-1-2*i -: 2]};
      t    = (c2e_pkg::SQ_REM_W + 2)'({root_p, 2'b01});
      ge   = r2 >= t;
    end
    always_ff @(posedge clk) begin
      rem_s[i]  <= ge ? c2e_pkg::SQ_REM_W'(r2 - t) : c2e_pkg::SQ_REM_W'(r2);
      root_s[i] <= {root_p[c2e_pkg::SQ_STEPS-2:0], ge};
      val_s[i]  <= val_p;
    end
  end

  assign root = root_s[c2e_pkg::SQ_STEPS-1];

endmodule

// ----- hw/rtl/c2e_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_cordic
// Pipelined vectoring CORDIC, one rotation per stage, binary angle out.
// ----------------------------------------------------------------------------
module c2e_cordic (
  input  logic                          clk,
  input  logic signed [c2e_pkg::CW-1:0] x_in,
  input  logic signed [c2e_pkg::CW-1:0] y_in,
  output logic signed [c2e_pkg::CW-1:0] z_out
);

  logic signed [c2e_pkg::CW-1:0] x_s [c2e_pkg::CORDIC_STEPS];
  logic signed [c2e_pkg::CW-1:0] y_s [c2e_pkg::CORDIC_STEPS];
  logic signed [c2e_pkg::CW-1:0] z_s [c2e_pkg::CORDIC_STEPS];

  for (genvar i = 0; i < c2e_pkg::CORDIC_STEPS; i++) begin : g_step
    logic signed [c2e_pkg::CW-1:0] xp, yp, zp, ang;
    if (i == 0) begin : g_first
      assign xp = x_in;
      assign yp = y_in;
      assign zp = '0;
    end else begin : g_rest
      assign xp = x_s[i-1];
      assign yp = y_s[i-1];
      assign zp = z_s[i-1];
    end
    assign ang = $signed(c2e_pkg::CW'(c2e_pkg::ATAN_TAB[i]));
    always_ff @(posedge clk) begin
      if (!yp[c2e_pkg::CW-1]) begin
        x_s[i] <= xp + (yp >>> i);
        y_s[i] <= yp - (xp >>> i);
        z_s[i] <= zp + ang;
      end else begin
        x_s[i] <= xp - (yp >>> i);
        y_s[i] <= yp + (xp >>> i);
        z_s[i] <= zp - ang;
      end
    end
  end

  assign z_out = z_s[c2e_pkg::CORDIC_STEPS-1];

endmodule

// ----- hw/rtl/c2e_back.sv -----
`timescale 1ns / 1ps
`include "cubemap_to_equirect_map_macros.svh"
// ----------------------------------------------------------------------------
// c2e_back
// Angle pipeline: root, two CORDICs, face rules and scaling to map units.
// ----------------------------------------------------------------------------
module c2e_back #(
  parameter int FRAC_BITS = c2e_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  c2e_pkg::item_t                item,
  input  logic [c2e_pkg::PW_W-1:0]      eq_width,
  input  logic [c2e_pkg::PH_W-1:0]      eq_height,
  output logic                          pop,
  output logic                          done,
  output logic [c2e_pkg::MAPX_W-1:0]    map_x,
  output logic [c2e_pkg::MAPY_W-1:0]    map_y,
  output logic                          outside
);

  localparam int CW  = c2e_pkg::CW;
  localparam int SQN = c2e_pkg::SQ_STEPS;
  localparam int CDN = c2e_pkg::CORDIC_STEPS;
  localparam int XSH = 32 - FRAC_BITS;
  localparam int YSH = 31 - FRAC_BITS;
  localparam int XW  = (48 - XSH > c2e_pkg::MAPX_W + 1) ? 48 - XSH : c2e_pkg::MAPX_W + 1;
  localparam int YW  = (47 - YSH > c2e_pkg::MAPY_W + 1) ? 47 - YSH : c2e_pkg::MAPY_W + 1;

  // request intake: squares and first CORDIC operands
  logic                            side;
  logic signed [c2e_pkg::XY_W-1:0] p;
  logic signed [2*c2e_pkg::XY_W-1:0] psq, xsq;
  logic signed [CW-1:0]            fxe, fye, we;
  c2e_pkg::sq_sb_t                 sb_next;
  logic                            b0_valid;
  c2e_pkg::sq_sb_t                 b0_sb;
  logic [c2e_pkg::SQ_IN_W-1:0]     b0_sqp, b0_sqx;
  logic [c2e_pkg::SQ_IN_W-1:0]     sq_sum;
  logic [SQN-1:0]                  root;

  logic                            sq_v [SQN];
  c2e_pkg::sq_sb_t                 sq_d [SQN];
  c2e_pkg::sq_sb_t                 sq_o;
  logic signed [CW-1:0]            c2x, c2y, z1, z2;
  logic                            cd_v [CDN];
  c2e_pkg::tag_t                   cd_d [CDN];
  c2e_pkg::tag_t                   tg;

  logic signed [CW-1:0]            a, theta, phi;
  logic                            f1_valid, f1_out;
  logic [31:0]                     f1_theta, f1_phi;
  logic                            f2_valid, f2_out;
  logic [45:0]                     f2_xprod;
  logic [44:0]                     f2_yprod;
  logic [46:0]                     xsum;
  logic [45:0]                     ysum;
  logic [XW-1:0]                   xf;
  logic [YW-1:0]                   yf;

  assign pop = !empty;

  always_comb begin
    side = item.face == c2e_pkg::FACE_LEFT || item.face == c2e_pkg::FACE_MID ||
           item.face == c2e_pkg::FACE_RIGHT || item.face == c2e_pkg::FACE_BACK;
    p    = side ? $signed({1'b0, item.w}) : item.fy;
    psq  = p * p;
    xsq  = item.fx * item.fx;
    fxe  = CW'(item.fx);
    fye  = CW'(item.fy);
    we   = $signed(CW'(item.w));
    sb_next.tag.outside = item.outside;
    sb_next.tag.face    = item.face;
    sb_next.tag.x_neg   = item.fx[c2e_pkg::XY_W-1];
    sb_next.tag.center  = (item.fx == '0) && (item.fy == '0);
    sb_next.w  = item.w;
    sb_next.fy = item.fy;
    if (side) begin
      sb_next.c1x = we <<< c2e_pkg::SCALE_SH;
      sb_next.c1y = fxe <<< c2e_pkg::SCALE_SH;
    end else begin
      sb_next.c1x = (fxe[CW-1] ? -fxe : fxe) <<< c2e_pkg::SCALE_SH;
      sb_next.c1y = (-fye) <<< c2e_pkg::SCALE_SH;
    end
  end

  always_ff @(posedge clk) begin
    b0_sb  <= sb_next;
    b0_sqp <= psq[c2e_pkg::SQ_IN_W-1:0];
    b0_sqx <= xsq[c2e_pkg::SQ_IN_W-1:0];
  end

  assign sq_sum = b0_sqp + b0_sqx;

  c2e_isqrt u_isqrt (
    .clk  (clk),
    .s_in (sq_sum),
    .root (root)
  );

  // sideband rides alongside the root and CORDIC pipelines
  always_ff @(posedge clk) begin
    sq_d[0] <= b0_sb;
    for (int i = 1; i < SQN; i++) sq_d[i] <= sq_d[i-1];
    cd_d[0] <= sq_o.tag;
    for (int i = 1; i < CDN; i++) cd_d[i] <= cd_d[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
      for (int i = 0; i < SQN; i++) sq_v[i] <= 1'b0;
      for (int i = 0; i < CDN; i++) cd_v[i] <= 1'b0;
    end else begin
      b0_valid <= pop;
      sq_v[0]  <= b0_valid;
      for (int i = 1; i < SQN; i++) sq_v[i] <= sq_v[i-1];
      cd_v[0]  <= sq_v[SQN-1];
      for (int i = 1; i < CDN; i++) cd_v[i] <= cd_v[i-1];
    end
  end

  assign sq_o = sq_d[SQN-1];

  always_comb begin
    if (sq_o.tag.face == c2e_pkg::FACE_TOP || sq_o.tag.face == c2e_pkg::FACE_BOTTOM) begin
      c2x = $signed(CW'(sq_o.w)) <<< c2e_pkg::SCALE_SH;
      c2y = $signed(CW'(root));
    end else begin
      c2x = $signed(CW'(root));
      c2y = $signed(CW'(sq_o.fy)) <<< c2e_pkg::SCALE_SH;
    end
  end

  c2e_cordic u_cordic_az (
    .clk   (clk),
    .x_in  (sq_o.c1x),
    .y_in  (sq_o.c1y),
    .z_out (z1)
  );

  c2e_cordic u_cordic_el (
    .clk   (clk),
    .x_in  (c2x),
    .y_in  (c2y),
    .z_out (z2)
  );

  assign tg = cd_d[CDN-1];

  // face rules
  always_comb begin
    a = c2e_pkg::ANG_HALF_PI + z1;
    unique case (tg.face)
      c2e_pkg::FACE_LEFT: begin
        theta = z1 + c2e_pkg::ANG_HALF_PI;
        phi   = c2e_pkg::ANG_HALF_PI - z2;
      end
      c2e_pkg::FACE_MID: begin
        theta = z1 + c2e_pkg::ANG_PI;
        phi   = c2e_pkg::ANG_HALF_PI - z2;
      end
      c2e_pkg::FACE_RIGHT: begin
        theta = z1 + c2e_pkg::ANG_3HALF_PI;
        phi   = c2e_pkg::ANG_HALF_PI - z2;
      end
      c2e_pkg::FACE_BACK: begin
        theta = z1;
        phi   = c2e_pkg::ANG_HALF_PI - z2;
      end
      c2e_pkg::FACE_TOP: begin
        theta = tg.center ? '0 : (tg.x_neg ? a : -a);
        phi   = z2;
      end
      c2e_pkg::FACE_BOTTOM: begin
        theta = tg.center ? '0 :
                (tg.x_neg ? c2e_pkg::ANG_PI - a : c2e_pkg::ANG_PI + a);
        phi   = c2e_pkg::ANG_PI - z2;
      end
      default: begin
        theta = '0;
        phi   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    f1_out   <= tg.outside;
    f1_theta <= theta[31:0];
    if (phi[CW-1])              f1_phi <= '0;
    else if (phi > c2e_pkg::ANG_PI) f1_phi <= c2e_pkg::ANG_PI[31:0];
    else                        f1_phi <= phi[31:0];
    f2_out   <= f1_out;
    f2_xprod <= f1_theta * eq_width;
    f2_yprod <= f1_phi * eq_height;
  end

  always_comb begin
    xsum = 47'(f2_xprod) + (47'(1) << (XSH - 1));
    ysum = 46'(f2_yprod) + (46'(1) << (YSH - 1));
    xf   = XW'(xsum >> XSH) + (XW'(2) << FRAC_BITS);
    yf   = YW'(ysum >> YSH) + (YW'(2) << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      f1_valid <= cd_v[CDN-1];
      f2_valid <= f1_valid;
      done     <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    outside <= f2_out;
    if (f2_out) begin
      map_x <= '0;
      map_y <= '0;
    end else begin
      map_x <= (xf > XW'(c2e_pkg::MAPX_MAX)) ? c2e_pkg::MAPX_MAX : xf[c2e_pkg::MAPX_W-1:0];
      map_y <= (yf > YW'(c2e_pkg::MAPY_MAX)) ? c2e_pkg::MAPY_MAX : yf[c2e_pkg::MAPY_W-1:0];
    end
  end

  `C2E_ASSERT_IMPL(a_outside_zero, clk, rst, done && outside, map_x == '0 && map_y == '0)
  `C2E_ASSERT_IMPL(a_phi_range, clk, rst, f1_valid, f1_phi <= c2e_pkg::ANG_PI[31:0])
  `C2E_ASSERT_NEXT(a_pipe_flow, clk, rst, f2_valid, done)

endmodule

// ----- hw/rtl/cubemap_to_equirect_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubemap_to_equirect_map
// Cube face pixel to equirectangular source position, one pixel per clock.
// ----------------------------------------------------------------------------
// A request (col, row) is taken whenever start is high and busy is low; a new
// one may follow every clock. Each request gives exactly one result, in order,
// shown for one cycle with done high. Two classifier stages, the queue, a
// squaring stage, the 29-stage square root, the 30-stage CORDIC and three
// scaling stages make up the pipeline; throughput is one pixel per clock. The
// receiver cannot stall; the back end drains the queue every clock, so busy
// stays low. Registers are written with cfg_we; write them only while no
// request is in flight.
module cubemap_to_equirect_map #(
  parameter int FRAC_BITS = c2e_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [c2e_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [c2e_pkg::PW_W-1:0]        cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [c2e_pkg::COL_W-1:0]       col,
  input  logic [c2e_pkg::ROW_W-1:0]       row,
  output logic                            done,
  output logic [c2e_pkg::MAPX_W-1:0]      map_x,
  output logic [c2e_pkg::MAPY_W-1:0]      map_y,
  output logic                            outside
);

  logic [c2e_pkg::PW_W-1:0] eq_width;
  logic [c2e_pkg::PH_W-1:0] eq_height;
  logic                     layout_strip;
  logic                     full, empty, push, pop;
  c2e_pkg::item_t           q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      eq_width     <= 14'd4096;
      eq_height    <= 13'd2048;
      layout_strip <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c2e_pkg::REG_EQ_WIDTH:     eq_width     <= cfg_data;
        c2e_pkg::REG_EQ_HEIGHT:    eq_height    <= cfg_data[c2e_pkg::PH_W-1:0];
        c2e_pkg::REG_LAYOUT_STRIP: layout_strip <= cfg_data[0];
        default: ;
      endcase
    end
  end

  c2e_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .col          (col),
    .row          (row),
    .eq_width     (eq_width),
    .layout_strip (layout_strip),
    .full         (full),
    .busy         (busy),
    .push         (push),
    .item         (q_in)
  );

  c2e_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_in),
    .pop   (pop),
    .dout  (q_out),
    .full  (full),
    .empty (empty)
  );

  c2e_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .item        (q_out),
    .eq_width    (eq_width),
    .eq_height   (eq_height),
    .pop         (pop),
    .done        (done),
    .map_x       (map_x),
    .map_y       (map_y),
    .outside     (outside)
  );

endmodule

// ----- tb/cubemap_to_equirect_map_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubemap_to_equirect_map_tb
// Sends cube pixels under several panorama sizes and both layouts, predicts
// each map position with a bit-exact CORDIC/isqrt model and checks results.
// ----------------------------------------------------------------------------
module cubemap_to_equirect_map_tb;

  typedef struct {
    logic [c2e_pkg::MAPX_W-1:0] mx;
    logic [c2e_pkg::MAPY_W-1:0] my;
    logic                       outs;
  } map_t;

  localparam longint HALF_TURN_Q = 64'd1073741824;
  localparam longint PI_ANG      = 64'd2147483648;
  localparam longint KW_MUL      = 64'd966707283;
  localparam int     FB          = c2e_pkg::FRAC_BITS_DEF;
  localparam int     LATENCY     = 66;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [c2e_pkg::CFG_IDX_W-1:0] cfg_index = c2e_pkg::REG_EQ_WIDTH;
  logic [c2e_pkg::PW_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic [c2e_pkg::COL_W-1:0] col = '0;
  logic [c2e_pkg::ROW_W-1:0] row = '0;
  logic busy, done, outside;
  logic [c2e_pkg::MAPX_W-1:0] map_x;
  logic [c2e_pkg::MAPY_W-1:0] map_y;

  map_t maps_pending[$];
  int errors = 0;
  int burst_left = 0;

  // shadow of the block's registers
  longint pw = 4096;
  longint ph = 2048;
  bit     strip = 1'b1;

  longint atan_q[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  cubemap_to_equirect_map DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .col(col), .row(row),
    .done(done), .map_x(map_x), .map_y(map_y), .outside(outside)
  );

  always #6 clk = ~clk;

  function automatic longint face_edge();
    return (pw * KW_MUL) >>> 32;
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q[i];
      end else begin
        x -= dx; y += dy; z -= atan_q[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic map_t source_position(longint c, longint r);
    map_t m;
    longint w, bx, by, fi, fj, u, v, X, Y, R, theta, phi, ps, ax, a;
    longint unsigned tu, xf, yf, hyp;
    w = face_edge();
    m.mx = '0; m.my = '0; m.outs = 1'b1;
    if (w == 0 || c >= (strip ? 6 * w : 3 * w) || r >= (strip ? w : 2 * w))
      return m;
    if (c >= 3 * w) begin
      bx = c - 3 * w; by = r + w;
    end else begin
      bx = c; by = r;
    end
    fi = bx / w; fj = by / w;
    u = bx - fi * w; v = by - fj * w;
    X = 2 * u - w; Y = w - 2 * v; R = w;
    if (fj == 0 || fi == 0) begin
      hyp = int_root(longint'(R * R + X * X) << 32);
      theta = cordic_angle(R * 65536, X * 65536);
      phi = HALF_TURN_Q - cordic_angle(longint'(hyp), Y * 65536);
      if (fj == 0) theta += HALF_TURN_Q * (fi + 1);
    end else begin
      hyp = int_root(longint'(X * X + Y * Y) << 32);
      ps = cordic_angle(R * 65536, longint'(hyp));
      if (X == 0 && Y == 0) begin
        theta = 0;
      end else begin
        ax = X < 0 ? -X : X;
        a = HALF_TURN_Q + cordic_angle(ax * 65536, -Y * 65536);
        if (fi == 1) theta = (X >= 0) ? -a : a;
        else theta = (X >= 0) ? (PI_ANG + a) : (PI_ANG - a);
      end
      phi = (fi == 1) ? ps : (PI_ANG - ps);
    end
    if (phi < 0) phi = 0;
    if (phi > PI_ANG) phi = PI_ANG;
    tu = theta & 64'hFFFF_FFFF;
    xf = (tu * pw + (64'd1 << (31 - FB))) >> (32 - FB);
    yf = (longint'(phi) * ph + (64'd1 << (30 - FB))) >> (31 - FB);
    xf += 64'd2 << FB;
    yf += 64'd2 << FB;
    if (xf > 64'(c2e_pkg::MAPX_MAX)) xf = 64'(c2e_pkg::MAPX_MAX);
    if (yf > 64'(c2e_pkg::MAPY_MAX)) yf = 64'(c2e_pkg::MAPY_MAX);
    m.mx = xf[c2e_pkg::MAPX_W-1:0]; m.my = yf[c2e_pkg::MAPY_W-1:0]; m.outs = 1'b0;
    return m;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    map_t e;
    if (!rst && done) begin
      if (maps_pending.size() == 0) begin
        report_mismatch("unexpected result, pending", 1, 0);
      end else begin
        e = maps_pending.pop_front();
        if (outside !== e.outs) report_mismatch("outside", outside, e.outs);
        if (map_x !== e.mx) report_mismatch("map_x", map_x, e.mx);
        if (map_y !== e.my) report_mismatch("map_y", map_y, e.my);
      end
    end
  end

  // bursts of random length, random gaps between them
  task automatic send_pixel(longint c, longint r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    col <= c[c2e_pkg::COL_W-1:0];
    row <= r[c2e_pkg::ROW_W-1:0];
    do @(posedge clk); while (busy);
    maps_pending.insert(maps_pending.size(),
                        source_position(c[c2e_pkg::COL_W-1:0], r[c2e_pkg::ROW_W-1:0]));
  endtask

  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (maps_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [c2e_pkg::CFG_IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[c2e_pkg::PW_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == c2e_pkg::REG_EQ_WIDTH) pw = val & 16'h3FFF;
    else if (idx == c2e_pkg::REG_EQ_HEIGHT) ph = val & 16'h1FFF;
    else if (idx == c2e_pkg::REG_LAYOUT_STRIP) strip = val[0];
  endtask

  task automatic set_panorama(longint wv, longint hv, bit s);
    settle();
    write_reg(c2e_pkg::REG_EQ_WIDTH, wv);
    write_reg(c2e_pkg::REG_EQ_HEIGHT, hv);
    write_reg(c2e_pkg::REG_LAYOUT_STRIP, s);
  endtask

  task automatic test_directed_corners();
    longint w;
    w = face_edge();
    send_pixel(0, 0);
    send_pixel(6 * w - 1, w - 1);
    send_pixel(6 * w, 0);                 // just beyond the strip
    send_pixel(0, w);
    send_pixel(32767, 8191);
    send_pixel(0, 8191);
    send_pixel(32767, 0);
    for (int f = 0; f < 6; f++) send_pixel(f * w + w / 2, w / 2);
    send_pixel(4 * w + w / 2 - 1, w / 2 - 1);
    send_pixel(5 * w + 1, w - 1);
  endtask

  task automatic test_grid_layout();
    longint w;
    set_panorama(4096, 2048, 1'b0);
    w = face_edge();
    send_pixel(3 * w - 1, 2 * w - 1);
    send_pixel(3 * w, 0);
    send_pixel(0, 2 * w);
    send_pixel(w + w / 2, w + w / 2);     // top centre
    send_pixel(2 * w + w / 2, w + w / 2); // bottom centre
    send_pixel(w / 2, w + 3);
  endtask

  task automatic test_register_extremes();
    set_panorama(0, 0, 1'b1);             // no faces at all
    send_pixel(0, 0);
    send_pixel(5, 1);
    set_panorama(16, 8, 1'b1);
    for (int c = 0; c < 19; c++) send_pixel(c, c % 4);
    set_panorama(16383, 8191, 1'b1);
    send_pixel(0, 0);
    send_pixel(6 * face_edge() - 1, face_edge() - 1);
    send_pixel(3 * face_edge() - 1, face_edge() / 2);
  endtask

  task automatic test_random_pixels(int n);
    longint w;
    w = face_edge();
    for (int i = 0; i < n; i++) begin
      if (w == 0 || $urandom_range(0, 9) == 0)
        send_pixel($urandom_range(0, 32767), $urandom_range(0, 8191));
      else
        send_pixel($urandom_range(0, (strip ? 6 : 3) * w - 1),
                   $urandom_range(0, (strip ? 1 : 2) * w - 1));
    end
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_panorama(4096, 2048, 1'b1);
        1: set_panorama(16383, 8191, 1'b0);
        2: set_panorama(16, 8, 1'b0);
        default: set_panorama($urandom_range(16, 16383), $urandom_range(8, 8191),
                              $urandom_range(0, 1));
      endcase
      test_random_pixels(225);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_grid_layout();
    test_register_extremes();
    test_random_settings();
    settle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
